@@ src/apf_pkg.sv @@
package apf_pkg;

	localparam int NAME_MAX_BYTES = 32;
	localparam int PATTERN_LENGTH = 15;
	localparam int NAME_SLOTS     = 32;

	localparam logic [15:0] MAGIC_RESET = 16'hAABB;

	localparam logic [7:0] TYPE_SHORT_NAME    = 8'h08;
	localparam logic [7:0] TYPE_COMPLETE_NAME = 8'h09;
	localparam logic [7:0] TYPE_MFR_DATA      = 8'hFF;
	localparam logic [7:0] BYTE_LIMIT         = 8'hFF;

	// parse phase codes
	localparam logic [1:0] PH_LEN  = 2'd0;
	localparam logic [1:0] PH_TYPE = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	// field kind codes
	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_NAME  = 2'd1;
	localparam logic [1:0] KIND_MFR   = 2'd2;

	// manufacturer magic progress codes
	localparam logic [1:0] MP_NONE  = 2'd0;
	localparam logic [1:0] MP_FIRST = 2'd1;
	localparam logic [1:0] MP_BOTH  = 2'd2;
	localparam logic [1:0] MP_FAIL  = 2'd3;

	// server name, zero padded; only the first PATTERN_LENGTH entries are compared
	localparam logic [7:0] SERVER_NAME [0:NAME_SLOTS-1] = '{
		8'h73, 8'h6C, 8'h65, 8'h5F, 8'h75, 8'h61, 8'h72, 8'h74,
		8'h5F, 8'h73, 8'h65, 8'h72, 8'h76, 8'h65, 8'h72, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef struct packed {
		logic       shift;
		logic [7:0] data;
	} win_ctl_t;

endpackage

@@ src/apf_if.sv @@
interface apf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       is_final_byte;

	modport source (output valid, output payload_byte, output is_final_byte, input ready);
	modport sink (input valid, input payload_byte, input is_final_byte, output ready);
endinterface

interface apf_flags_if;
	logic valid;
	logic ready;
	logic any_match;
	logic name_match;
	logic magic_match;

	modport source (output valid, output any_match, output name_match, output magic_match,
		input ready);
	modport sink (input valid, input any_match, input name_match, input magic_match,
		output ready);
endinterface

@@ src/apf_name_window.sv @@
module apf_name_window (
	input  logic              clk,
	input  apf_pkg::win_ctl_t ctl,
	output logic              hit
);

	logic [7:0] win_q  [0:apf_pkg::PATTERN_LENGTH-1];
	logic [7:0] win_nx [0:apf_pkg::PATTERN_LENGTH-1];

	// newest byte enters slot zero
	assign win_nx[0] = ctl.data;
	for (genvar k = 1; k < apf_pkg::PATTERN_LENGTH; k++) begin : g_shift
		assign win_nx[k] = win_q[k-1];
	end

	// oldest slot holds the first character of the name
	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < apf_pkg::PATTERN_LENGTH; i++) begin
			if (win_nx[apf_pkg::PATTERN_LENGTH-1-i] != apf_pkg::SERVER_NAME[i]) begin
				hit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			win_q <= win_nx;
		end
	end

endmodule

@@ src/advertising_payload_filter_core.sv @@
// Path: an accepted beat loads the input register; when a final beat leaves it, its flags
//   load the result register and appear on result.valid.
// Throughput: one payload byte per cycle; a final byte waits in the input register
//   only while the previous result is still untaken, other bytes never wait.
// Reset (arst_n low): parser state, parser flags and valid bits clear; magic word returns to 0xaabb.
module advertising_payload_filter_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,
	apf_byte_if.sink       rx,
	apf_flags_if.source    result
);

	// configuration
	logic [15:0] magic_word_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// parser state
	logic [1:0] phase_q, phase_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] remain_q, remain_d;
	logic [1:0] kind_q, kind_d;
	logic [7:0] idx_q, idx_d;
	logic       ended_q, ended_d;
	logic       found_q, found_d;
	logic [1:0] prog_q, prog_d;
	logic       name_flag_q, name_flag_d;
	logic       mfr_flag_q, mfr_flag_d;

	// result register
	logic out_valid_q;
	logic any_q, name_q, magic_q;

	logic              advance;
	logic              fire;
	logic              walk;
	logic              field_end;
	logic [7:0]        remain_m1;
	apf_pkg::win_ctl_t win_ctl;
	logic              win_hit;

	// Drain the input register unless a final beat would overwrite an untaken result.
	assign advance  = !final_s1 || !out_valid_q || result.ready;
	assign fire     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	assign walk      = seen_q != apf_pkg::BYTE_LIMIT;
	assign remain_m1 = remain_q - 8'd1;

	// A name byte goes into the window only while the name is still open and within bounds.
	assign win_ctl.data  = byte_s1;
	assign win_ctl.shift = fire && walk && phase_q == apf_pkg::PH_DATA
		&& kind_q == apf_pkg::KIND_NAME && !ended_q
		&& idx_q < 8'(apf_pkg::NAME_MAX_BYTES) && byte_s1 != 8'd0;

	apf_name_window u_window (
		.clk (clk),
		.ctl (win_ctl),
		.hit (win_hit)
	);

	always_comb begin
		phase_d     = phase_q;
		seen_d      = seen_q;
		remain_d    = remain_q;
		kind_d      = kind_q;
		idx_d       = idx_q;
		ended_d     = ended_q;
		found_d     = found_q;
		prog_d      = prog_q;
		name_flag_d = name_flag_q;
		mfr_flag_d  = mfr_flag_q;
		field_end   = 1'b0;

		if (walk) begin
			seen_d = seen_q + 8'd1;
			case (phase_q)
				apf_pkg::PH_LEN: begin
					if (byte_s1 == 8'd0) begin
						phase_d = apf_pkg::PH_DONE;
					end else begin
						remain_d = byte_s1;
						phase_d  = apf_pkg::PH_TYPE;
					end
				end
				apf_pkg::PH_TYPE: begin
					if (byte_s1 inside {apf_pkg::TYPE_SHORT_NAME,
							apf_pkg::TYPE_COMPLETE_NAME}) begin
						kind_d = apf_pkg::KIND_NAME;
					end else if (byte_s1 == apf_pkg::TYPE_MFR_DATA) begin
						kind_d = apf_pkg::KIND_MFR;
					end else begin
						kind_d = apf_pkg::KIND_OTHER;
					end
					idx_d    = 8'd0;
					ended_d  = 1'b0;
					found_d  = 1'b0;
					prog_d   = apf_pkg::MP_NONE;
					remain_d = remain_m1;
					if (remain_m1 == 8'd0) begin
						field_end = 1'b1;
					end else begin
						phase_d = apf_pkg::PH_DATA;
					end
				end
				apf_pkg::PH_DATA: begin
					// name tracking: a zero byte closes the name
					if (kind_q == apf_pkg::KIND_NAME && !ended_q
							&& idx_q < 8'(apf_pkg::NAME_MAX_BYTES)) begin
						if (byte_s1 == 8'd0) begin
							ended_d = 1'b1;
						end else if (idx_q >= 8'(apf_pkg::PATTERN_LENGTH - 1) && win_hit) begin
							found_d = 1'b1;
						end
					end
					// magic word over the first two data bytes
					if (kind_q == apf_pkg::KIND_MFR) begin
						if (idx_q == 8'd0) begin
							prog_d = (byte_s1 == magic_word_q[15:8])
								? apf_pkg::MP_FIRST : apf_pkg::MP_FAIL;
						end else if (idx_q == 8'd1 && prog_q == apf_pkg::MP_FIRST) begin
							prog_d = (byte_s1 == magic_word_q[7:0])
								? apf_pkg::MP_BOTH : apf_pkg::MP_FAIL;
						end
					end
					if (idx_q != apf_pkg::BYTE_LIMIT) begin
						idx_d = idx_q + 8'd1;
					end
					remain_d = remain_m1;
					field_end = remain_m1 == 8'd0;
				end
				default: begin
				end
			endcase

			// A field counts only once its last byte is in.
			if (field_end) begin
				name_flag_d = name_flag_q || found_d;
				mfr_flag_d  = mfr_flag_q || prog_d == apf_pkg::MP_BOTH;
				phase_d     = apf_pkg::PH_LEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q <= apf_pkg::MAGIC_RESET;
		end else if (cfg_we) begin
			magic_word_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1  <= rx.payload_byte;
			final_s1 <= rx.is_final_byte;
		end
	end

	// Advance the parser on each byte; drop back to the start state after the final one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= apf_pkg::PH_LEN;
			seen_q      <= 8'd0;
			remain_q    <= 8'd0;
			kind_q      <= apf_pkg::KIND_OTHER;
			idx_q       <= 8'd0;
			ended_q     <= 1'b0;
			found_q     <= 1'b0;
			prog_q      <= apf_pkg::MP_NONE;
			name_flag_q <= 1'b0;
			mfr_flag_q  <= 1'b0;
		end else if (fire) begin
			if (final_s1) begin
				phase_q     <= apf_pkg::PH_LEN;
				seen_q      <= 8'd0;
				remain_q    <= 8'd0;
				kind_q      <= apf_pkg::KIND_OTHER;
				idx_q       <= 8'd0;
				ended_q     <= 1'b0;
				found_q     <= 1'b0;
				prog_q      <= apf_pkg::MP_NONE;
				name_flag_q <= 1'b0;
				mfr_flag_q  <= 1'b0;
			end else begin
				phase_q     <= phase_d;
				seen_q      <= seen_d;
				remain_q    <= remain_d;
				kind_q      <= kind_d;
				idx_q       <= idx_d;
				ended_q     <= ended_d;
				found_q     <= found_d;
				prog_q      <= prog_d;
				name_flag_q <= name_flag_d;
				mfr_flag_q  <= mfr_flag_d;
			end
		end
	end

	// Result register: hold flags until the sink takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && final_s1) begin
			any_q   <= name_flag_d || mfr_flag_d;
			name_q  <= name_flag_d;
			magic_q <= mfr_flag_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.any_match   = any_q;
	assign result.name_match  = name_q;
	assign result.magic_match = magic_q;

endmodule
